/* design/jpg_pkg.sv */
// Shared types and constants for the Josephus permutation generator.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package jpg_pkg;

  // Circle capacity and derived widths
  localparam int MAX_PEOPLE = 1024;
  localparam int SEAT_W     = $clog2(MAX_PEOPLE);
  localparam int CNT_W      = $clog2(MAX_PEOPLE + 1);

  // Fixed widths of registers and item fields
  localparam int CFG_W      = 11;
  localparam int PERSON_W   = 11;
  localparam int DIV_CNT_W  = $clog2(CFG_W + 1);

  // Configuration register indexes
  localparam int REG_PEOPLE_COUNT = 0;
  localparam int REG_STEP_COUNT   = 1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic refill;     // latch round size, refill counters, restart clear sweep
    logic clear;      // mark one seat alive, advance sweep address
    logic div_load;   // start passes = (k-1) mod remaining
    logic div_step;   // one restoring division step
    logic scan_load;  // start the seat scan at the cursor
    logic scan_step;  // issue one seat read, check the returning one
    logic kill;       // mark the found seat dead, update cursor and count
    logic emit;       // load the result into the output register
  } jpg_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic round_done;  // no living people left in the round
    logic clear_last;  // sweep is at the last seat
    logic div_done;    // division finished
    logic hit;         // returning seat is the one to remove
    logic out_free;    // output register can take a result
  } jpg_status_t;

endpackage

`default_nettype wire

/* design/jpg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module jpg_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* design/jpg_ctrl.sv */
// Controller state machine: sequences refill sweep, division, seat scan and emit.
// Depends on jpg_pkg for the command and status structs.
`default_nettype none

module jpg_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_restart_i,
  output logic                     in_ready_o,
  input  wire jpg_pkg::jpg_status_t status_i,
  output jpg_pkg::jpg_cmd_t        cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DIV,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_restart_i || status_i.round_done) begin
            cmd_o.refill = 1'b1;
            state_d      = ST_CLEAR;
          end else begin
            cmd_o.div_load = 1'b1;
            state_d        = ST_DIV;
          end
        end
      end
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          cmd_o.div_load = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          cmd_o.scan_load = 1'b1;
          state_d         = ST_SCAN;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.hit) begin
          cmd_o.kill = 1'b1;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* design/jpg_datapath.sv */
// Datapath: round counters, alive-mark RAM, restoring divider, seat scan, output register.
// Depends on jpg_pkg and jpg_ram.
`default_nettype none

module jpg_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [jpg_pkg::CFG_W-1:0]    people_count_i,
  input  wire logic [jpg_pkg::CFG_W-1:0]    step_count_i,
  input  wire jpg_pkg::jpg_cmd_t            cmd_i,
  output jpg_pkg::jpg_status_t              status_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [jpg_pkg::PERSON_W-1:0] out_person_o,
  output logic                              out_last_o
);

  localparam int SEAT_W = jpg_pkg::SEAT_W;
  localparam int CNT_W  = jpg_pkg::CNT_W;
  localparam int CFG_W  = jpg_pkg::CFG_W;

  // Next seat, wrapping within the round
  function automatic logic [SEAT_W-1:0] wrap_next(input logic [SEAT_W-1:0] seat,
                                                  input logic [CNT_W-1:0]  size);
    logic [CNT_W-1:0] nxt;
    nxt = CNT_W'(seat) + CNT_W'(1);
    return (nxt >= size) ? '0 : nxt[SEAT_W-1:0];
  endfunction

  logic [CNT_W-1:0]            round_size_q, remaining_q;
  logic [SEAT_W-1:0]           cursor_q;
  logic [SEAT_W-1:0]           clr_addr_q;
  logic [CNT_W-1:0]            rem_q;
  logic [CFG_W-1:0]            dvd_q;
  logic [jpg_pkg::DIV_CNT_W-1:0] div_cnt_q;
  logic [SEAT_W-1:0]           rd_seat_q, chk_seat_q, found_seat_q;
  logic                        chk_valid_q;
  logic [CNT_W-1:0]            pass_cnt_q;
  logic                        out_valid_q, out_last_q;
  logic [jpg_pkg::PERSON_W-1:0] out_person_q;

  logic [CNT_W-1:0]  n_clamped;
  logic [CFG_W-1:0]  k_minus_one;
  logic [CNT_W:0]    trial;
  logic              alive_rd;
  logic              ram_we, ram_wdata;
  logic [SEAT_W-1:0] ram_waddr;
  logic              living;
  logic [CNT_W-1:0]  person_wide;

  // Clamp n into 1..MAX_PEOPLE, k into 1..
  always_comb begin
    if (people_count_i == '0) begin
      n_clamped = CNT_W'(1);
    end else if ({21'd0, people_count_i} > jpg_pkg::MAX_PEOPLE) begin
      n_clamped = CNT_W'(jpg_pkg::MAX_PEOPLE);
    end else begin
      n_clamped = CNT_W'(people_count_i);
    end
  end
  assign k_minus_one = (step_count_i == '0) ? '0 : step_count_i - CFG_W'(1);

  // Restoring division trial
  assign trial = {rem_q, dvd_q[CFG_W-1]};

  // Alive-mark RAM: sweep writes ones, a kill writes a zero
  assign ram_we    = cmd_i.clear | cmd_i.kill;
  assign ram_waddr = cmd_i.clear ? clr_addr_q : chk_seat_q;
  assign ram_wdata = cmd_i.clear;

  jpg_ram #(
    .WIDTH (1),
    .DEPTH (jpg_pkg::MAX_PEOPLE)
  ) u_alive_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_seat_q),
    .rdata_o (alive_rd)
  );

  assign living = chk_valid_q & alive_rd;

  // Status back to the controller
  assign status_o.round_done = (remaining_q == '0);
  assign status_o.clear_last = (clr_addr_q == SEAT_W'(jpg_pkg::MAX_PEOPLE - 1));
  assign status_o.div_done   = (div_cnt_q == '0);
  assign status_o.hit        = living & (pass_cnt_q == '0);
  assign status_o.out_free   = ~out_valid_q | out_ready_i;

  // Round state: size, living count, cursor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_size_q <= CNT_W'(1);
      remaining_q  <= '0;
      cursor_q     <= '0;
    end else if (cmd_i.refill) begin
      round_size_q <= n_clamped;
      remaining_q  <= n_clamped;
      cursor_q     <= '0;
    end else if (cmd_i.kill) begin
      remaining_q  <= remaining_q - CNT_W'(1);
      cursor_q     <= wrap_next(chk_seat_q, round_size_q);
    end
  end

  // Clear sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.refill) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_addr_q <= clr_addr_q + SEAT_W'(1);
    end
  end

  // Divider: one quotient bit per cycle, keep only the remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_load) begin
      div_cnt_q <= jpg_pkg::DIV_CNT_W'(CFG_W);
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q - jpg_pkg::DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q <= '0;
      dvd_q <= k_minus_one;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[CFG_W-2:0], 1'b0};
      if (trial >= {1'b0, remaining_q}) begin
        rem_q <= CNT_W'(trial - {1'b0, remaining_q});
      end else begin
        rem_q <= trial[CNT_W-1:0];
      end
    end
  end

  // Scan: issue one read per cycle, check each seat when its mark returns in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_valid_q <= 1'b0;
    end else if (cmd_i.scan_load) begin
      chk_valid_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      chk_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_load) begin
      rd_seat_q  <= cursor_q;
      pass_cnt_q <= rem_q;
    end else if (cmd_i.scan_step) begin
      rd_seat_q  <= wrap_next(rd_seat_q, round_size_q);
      chk_seat_q <= rd_seat_q;
      if (living && pass_cnt_q != '0) begin
        pass_cnt_q <= pass_cnt_q - CNT_W'(1);
      end
    end
    if (cmd_i.kill) begin
      found_seat_q <= chk_seat_q;
    end
  end

  // Output register
  assign person_wide = CNT_W'(found_seat_q) + CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_person_q <= jpg_pkg::PERSON_W'(person_wide);
      out_last_q   <= (remaining_q == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_person_o = out_person_q;
  assign out_last_o   = out_last_q;

  // Living count never exceeds the round size
  assert property (@(posedge clk_i) disable iff (!rst_ni) remaining_q <= round_size_q)
    else $error("remaining count exceeds round size");

  // Cursor stays inside the round
  assert property (@(posedge clk_i) disable iff (!rst_ni) CNT_W'(cursor_q) < round_size_q)
    else $error("cursor outside the round");

  // A removal needs a living person left
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.kill |-> remaining_q != '0)
    else $error("removal with empty round");

  // A refill leaves a nonzero round
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cmd_i.refill |=> (round_size_q != '0 && remaining_q == round_size_q))
    else $error("refill produced bad round size");

endmodule

`default_nettype wire

/* design/josephus_permutation_generator.sv */
// Josephus permutation generator: each input item draws the next person removed from
// a circle of n people counting by k. An item that refills the circle (restart set, or
// the previous round finished) first sweeps all MAX_PEOPLE seats of the alive-mark RAM,
// one seat a cycle. Every item then goes through the bit-serial reduction of k-1
// modulo the living count, a scan of the alive marks at one seat a cycle starting at the
// cursor (a registered RAM read, then every seat visited, dead ones included, up to
// about one lap of the round), and the load of the output register once that is free.
// The scan length is the data-dependent part. A new item is taken only while the block is idle, but the
// output register lets it start while the previous result still waits to be taken.
// Depends on jpg_pkg, jpg_ctrl, jpg_datapath and jpg_ram.
`default_nettype none

module josephus_permutation_generator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  // Result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,   // [10:0] person, [15:11] zero
  output logic             m_axis_tlast,   // last person of the round
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int CFG_W = jpg_pkg::CFG_W;

  logic [CFG_W-1:0] people_count_q, step_count_q;
  logic             cfg_write;
  logic [0:0]       reg_index;
  jpg_pkg::jpg_cmd_t    cmd;
  jpg_pkg::jpg_status_t status;
  logic [jpg_pkg::PERSON_W-1:0] person;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign reg_index = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      people_count_q <= CFG_W'(1);
      step_count_q   <= CFG_W'(1);
    end else if (cfg_write) begin
      case (reg_index)
        1'(jpg_pkg::REG_PEOPLE_COUNT): people_count_q <= pwdata[CFG_W-1:0];
        1'(jpg_pkg::REG_STEP_COUNT):   step_count_q   <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_index)
      1'(jpg_pkg::REG_PEOPLE_COUNT): prdata = 32'(people_count_q);
      1'(jpg_pkg::REG_STEP_COUNT):   prdata = 32'(step_count_q);
      default:                       prdata = '0;
    endcase
  end

  jpg_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_restart_i (s_axis_tdata[0]),
    .in_ready_o   (s_axis_tready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  jpg_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .people_count_i (people_count_q),
    .step_count_i   (step_count_q),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_person_o   (person),
    .out_last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = 16'(person);

endmodule

`default_nettype wire

/* dv/josephus_permutation_generator_checker.sv */
// Result checker for the Josephus permutation generator: predicts each removal from the
// accepted requests and register writes, compares every result item with it, checks reads.
// Depends on jpg_pkg for widths, capacity and register indexes.
module josephus_permutation_generator_checker
  import jpg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [10:0] person, [15:11] zero
  input  logic        m_axis_tlast,   // last person of the round
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] person_word;
    logic        last;
  } removal_t;

  // Predicted circle and registers
  logic        seat_alive [MAX_PEOPLE];
  int unsigned seat_cursor;
  int unsigned living_left;
  int unsigned round_len;
  logic [CFG_W-1:0] people_reg;
  logic [CFG_W-1:0] step_reg;

  removal_t removals_due [$];
  removal_t oldest_due;
  int       mismatch_count;
  int       due_count;
  int       reg_index;
  logic [CFG_W-1:0] reg_value;

  assign fail_count_o = mismatch_count + due_count;

  // Seats past the round wrap to seat 0
  function automatic int unsigned wrap_seat(int unsigned s);
    return (s >= round_len) ? 0 : s;
  endfunction

  // First living seat at or after s, cyclically within the round
  function automatic int unsigned next_living(int unsigned s);
    int unsigned p;
    p = wrap_seat(s);
    for (int unsigned i = 0; i < round_len; i++) begin
      if (p < MAX_PEOPLE && seat_alive[p]) return p;
      p = wrap_seat(p + 1);
    end
    return 0;
  endfunction

  // Remove the next person and return the result item it produces
  function automatic removal_t draw_removal(logic restart);
    int unsigned n;
    int unsigned k;
    int unsigned passes;
    int unsigned seat;
    removal_t r;
    if (restart || living_left == 0) begin
      n = people_reg;
      if (n == 0) n = 1;
      if (n > MAX_PEOPLE) n = MAX_PEOPLE;
      round_len = n;
      foreach (seat_alive[i]) seat_alive[i] = 1'b1;
      living_left = n;
      seat_cursor = 0;
    end
    k = (step_reg == 0) ? 1 : step_reg;
    passes = (k - 1) % living_left;
    seat = next_living(seat_cursor);
    for (int unsigned i = 0; i < passes; i++) seat = next_living(seat + 1);
    seat_alive[seat] = 1'b0;
    living_left = living_left - 1;
    seat_cursor = wrap_seat(seat + 1);
    r.person_word = 16'(seat + 1);
    r.last = (living_left == 0);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (seat_alive[i]) seat_alive[i] = 1'b1;
      seat_cursor = 0;
      living_left = 0;
      round_len = 1;
      people_reg = 1;
      step_reg = 1;
      removals_due.delete();
      mismatch_count = 0;
    end else begin
      // Compare a result item with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (removals_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual person %0d last %0b",
                   $time, m_axis_tdata, m_axis_tlast);
          mismatch_count++;
        end else begin
          oldest_due = removals_due.pop_front();
          if (m_axis_tdata !== oldest_due.person_word) begin
            $display("%0t: person mismatch: expected %0d, actual %0d",
                     $time, oldest_due.person_word, m_axis_tdata);
            mismatch_count++;
          end
          if (m_axis_tlast !== oldest_due.last) begin
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, oldest_due.last, m_axis_tlast);
            mismatch_count++;
          end
        end
      end

      // Predict the removal for each accepted request item
      if (s_axis_tvalid && s_axis_tready)
        removals_due.push_back(draw_removal(s_axis_tdata[0]));

      // Track register writes, check register reads
      if (psel && penable && pready) begin
        reg_index = paddr >> 2;
        if (pwrite) begin
          if (reg_index == REG_PEOPLE_COUNT) people_reg = pwdata[CFG_W-1:0];
          else if (reg_index == REG_STEP_COUNT) step_reg = pwdata[CFG_W-1:0];
        end else if (reg_index == REG_PEOPLE_COUNT || reg_index == REG_STEP_COUNT) begin
          reg_value = (reg_index == REG_PEOPLE_COUNT) ? people_reg : step_reg;
          if (prdata[CFG_W-1:0] !== reg_value) begin
            $display("%0t: register %0d read mismatch: expected %0d, actual %0d",
                     $time, reg_index, reg_value, prdata[CFG_W-1:0]);
            mismatch_count++;
          end
        end
      end
      due_count = removals_due.size();
    end
  end

endmodule

/* dv/josephus_permutation_generator_test.sv */
// Testbench top for the Josephus permutation generator: drives request items, result
// back-pressure and register accesses, and gives the verdict from the checker's count.
// Depends on jpg_pkg, the block and josephus_permutation_generator_checker.
module josephus_permutation_generator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import jpg_pkg::*;

  localparam int RANDOM_ITEMS = 550;
  localparam int FLOOD_PHASE  = 5;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int requests_sent;
  int removals_taken;
  bit sender_quiet;
  bit flood_on;

  josephus_permutation_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  josephus_permutation_generator_checker removal_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .fail_count_o  (fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register access: setup cycle, then access until pready
  task automatic apb_access(bit is_write, int idx, int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= 3'(4 * idx);
    pwdata  <= {21'($urandom() >> 11), value[CFG_W-1:0]};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until every request has its result
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (removals_taken != requests_sent) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Reconfigure the idle block and read the registers back
  task automatic set_circle(int unsigned n, int unsigned k);
    settle();
    apb_access(1'b1, REG_PEOPLE_COUNT, n);
    apb_access(1'b1, REG_STEP_COUNT, k);
    apb_access(1'b0, REG_PEOPLE_COUNT, 0);
    apb_access(1'b0, REG_STEP_COUNT, 0);
  endtask

  // Offer one request item after a random gap
  task automatic send_request(bit restart);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, restart};
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
  endtask

  // Result side: random stalls, quiet stretches, one long hold during the flood phase
  initial begin
    bit rx_quiet;
    bit flood_done;
    int gap;
    rx_quiet = 1'b0;
    flood_done = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
      gap = rx_quiet ? 0 : $urandom_range(0, 15);
      if (flood_on && !flood_done) begin
        gap = 600;
        flood_done = 1'b1;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      removals_taken++;
    end
  end

  // Stimulus and verdict
  initial begin
    int unsigned n;
    int unsigned k;
    int unsigned n_eff;
    int count;
    int phase;
    int pick;
    requests_sent = 0;
    removals_taken = 0;
    sender_quiet = 1'b0;
    flood_on = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: a single person, round finished, so the first request refills
    apb_access(1'b0, REG_PEOPLE_COUNT, 0);
    apb_access(1'b0, REG_STEP_COUNT, 0);
    send_request(1'b0);
    send_request(1'b1);

    // Zero n and k act as one
    set_circle(0, 0);
    send_request(1'b0);
    send_request(1'b1);

    // Full round of five counting by two, then a request that starts the next round
    set_circle(5, 2);
    repeat (6) send_request(1'b0);

    // Step far beyond the living count
    set_circle(3, 1024);
    repeat (3) send_request(1'b0);

    // Circle size written mid-round takes effect only at the next refill
    set_circle(7, 3);
    repeat (2) send_request(1'b0);
    set_circle(4, 3);
    repeat (2) send_request(1'b0);
    send_request(1'b1);

    // Largest register values: n saturates to the capacity
    set_circle(2047, 2047);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
    set_circle(1024, 1);
    send_request(1'b1);
    send_request(1'b0);

    // Random phases: mostly small circles run through whole rounds, a few large ones
    phase = 0;
    while (requests_sent < 23 + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        case ($urandom_range(0, 3))
          0: n = 0;
          1: n = 1;
          2: n = 1024;
          default: n = 2047;
        endcase
      end else if (pick <= 2) begin
        n = $urandom_range(64, 1024);
      end else begin
        n = $urandom_range(1, 40);
      end
      n_eff = (n == 0) ? 1 : (n > MAX_PEOPLE) ? MAX_PEOPLE : n;
      case ($urandom_range(0, 3))
        0: k = $urandom_range(0, 2047);
        1: k = 1;
        default: k = $urandom_range(1, n_eff + 3);
      endcase
      if (n_eff > 40) count = $urandom_range(3, 10);
      else count = $urandom_range(1, (2 * n_eff + 2 > 80) ? 80 : 2 * n_eff + 2);
      sender_quiet = ($urandom_range(0, 3) == 0);
      if (phase == FLOOD_PHASE) begin
        n = 6;
        k = 2;
        count = 40;
        sender_quiet = 1'b1;
      end
      set_circle(n, k);
      flood_on = (phase == FLOOD_PHASE);
      repeat (count) send_request($urandom_range(0, 19) == 0);
      flood_on = 1'b0;
      phase++;
    end

    settle();
    repeat (64) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run limit
  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

endmodule
